// File: hdl/wsfs_pkg.sv
package wsfs_pkg;

   localparam int unsigned BITS_PER_LED = 24;
   localparam int unsigned BIT_IDX_W    = 5;
   localparam int unsigned COLOUR_W     = 24;
   localparam int unsigned INDEX_W      = 10;
   localparam int unsigned CHANNEL_W    = 8;
   localparam int unsigned CSR_INDEX_W  = 1;

   localparam int unsigned QUEUE_DEPTH  = 2;
   localparam int unsigned QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_COMPARE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_COMPARE = 1'b1;

   localparam logic [CHANNEL_W-1:0] ONE_COMPARE_RESET  = 8'd76;
   localparam logic [CHANNEL_W-1:0] ZERO_COMPARE_RESET = 8'd38;

   localparam logic [BIT_IDX_W-1:0] MSB_BIT = 5'(BITS_PER_LED - 1);

   typedef struct packed {
      logic                is_tick;
      logic [INDEX_W-1:0]  led_index;
      logic [COLOUR_W-1:0] colour;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef enum logic [1:0] {
      PH_DATA = 2'b01,
      PH_GAP  = 2'b10
   } phase_type;

endpackage

// File: hdl/wsfs_front.sv
module wsfs_front #(
   parameter int unsigned LED_COUNT = 8
) (
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_opcode,
   input  logic [9:0]                  req_led_index,
   input  logic [7:0]                  req_red,
   input  logic [7:0]                  req_green,
   input  logic [7:0]                  req_blue,
   input  wsfs_pkg::queue_stat_type    queue_stat,
   input  logic                        clearing,
   output logic                        push,
   output wsfs_pkg::cmd_type           cmd
);
   import wsfs_pkg::*;

   logic accept;
   logic in_range;

   assign busy     = queue_stat.full | clearing;
   assign accept   = start & ~busy;
   assign in_range = {1'b0, req_led_index} < (INDEX_W + 1)'(LED_COUNT);

   // out of range writes are dropped here and never reach the queue
   assign push = accept & ((req_opcode == OP_TICK) | in_range);

   assign cmd.is_tick   = (req_opcode == OP_TICK);
   assign cmd.led_index = req_led_index;
   assign cmd.colour    = {req_green, req_red, req_blue};

endmodule

// File: hdl/wsfs_queue.sv
module wsfs_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic                     pop,
   input  wsfs_pkg::cmd_type        cmd_in,
   output wsfs_pkg::cmd_type        cmd_out,
   output wsfs_pkg::queue_stat_type stat
);
   import wsfs_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign stat.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push & ~stat.full;
   assign do_pop     = pop & ~stat.empty;
   assign cmd_out    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// File: hdl/wsfs_back.sv
module wsfs_back #(
   parameter int unsigned LED_COUNT   = 8,
   parameter int unsigned RESET_SLOTS = 60
) (
   input  logic                     clock,
   input  logic                     reset,
   input  wsfs_pkg::cmd_type        cmd,
   input  wsfs_pkg::queue_stat_type queue_stat,
   output logic                     pop,
   output logic                     clearing,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [0:0]               csr_index,
   input  logic [7:0]               csr_data,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_compare_value,
   output logic                     rsp_frame_end
);
   import wsfs_pkg::*;

   localparam int unsigned LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int unsigned GAP_W     = (RESET_SLOTS > 1) ? $clog2(RESET_SLOTS) : 1;
   localparam logic [LED_IDX_W-1:0] LAST_LED = LED_IDX_W'(LED_COUNT - 1);
   localparam logic [GAP_W-1:0]     LAST_GAP = GAP_W'(RESET_SLOTS - 1);

   logic [COLOUR_W-1:0]  colour_mem [LED_COUNT];
   logic [COLOUR_W-1:0]  rd_data_ff;

   logic                 clr_active_ff, clr_active_in;
   logic [LED_IDX_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic [CHANNEL_W-1:0] one_cmp_ff, zero_cmp_ff;

   phase_type            phase_ff, phase_in;
   logic [LED_IDX_W-1:0] led_ff, led_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;
   logic [GAP_W-1:0]     gap_ff, gap_in;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_gap_ff;
   logic                 s1_fend_ff;
   logic [BIT_IDX_W-1:0] s1_bit_ff;

   logic                 rsp_valid_ff;
   logic [CHANNEL_W-1:0] rsp_cmp_ff;
   logic                 rsp_fend_ff;

   logic                 tick;
   logic                 wr_en;
   logic                 last_gap;

   assign clearing  = clr_active_ff;
   assign pop       = ~queue_stat.empty & ~clr_active_ff;
   assign tick      = pop & cmd.is_tick;
   assign wr_en     = pop & ~cmd.is_tick;
   assign csr_ready = 1'b1;
   assign last_gap  = (phase_ff == PH_GAP) && (gap_ff == LAST_GAP);

   // clearing pass over the colour store after reset
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_cnt_in    = clr_cnt_ff;
      if (clr_active_ff) begin
         if (clr_cnt_ff == LAST_LED) begin
            clr_active_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
      end
   end

   // slot counter: led, bit (msb first) and gap position
   always_comb begin
      phase_in = phase_ff;
      led_in   = led_ff;
      bit_in   = bit_ff;
      gap_in   = gap_ff;
      if (tick) begin
         unique case (phase_ff)
            PH_DATA: begin
               if (bit_ff == '0) begin
                  bit_in = MSB_BIT;
                  if (led_ff == LAST_LED) begin
                     phase_in = PH_GAP;
                     led_in   = '0;
                     gap_in   = '0;
                  end else begin
                     led_in = led_ff + 1'b1;
                  end
               end else begin
                  bit_in = bit_ff - 1'b1;
               end
            end
            PH_GAP: begin
               if (gap_ff == LAST_GAP) begin
                  phase_in = PH_DATA;
                  gap_in   = '0;
               end else begin
                  gap_in = gap_ff + 1'b1;
               end
            end
            default: begin
               phase_in = PH_DATA;
            end
         endcase
      end
   end

   assign s1_valid_in = tick;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
         phase_ff      <= PH_DATA;
         led_ff        <= '0;
         bit_ff        <= MSB_BIT;
         gap_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         one_cmp_ff    <= ONE_COMPARE_RESET;
         zero_cmp_ff   <= ZERO_COMPARE_RESET;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
         phase_ff      <= phase_in;
         led_ff        <= led_in;
         bit_ff        <= bit_in;
         gap_ff        <= gap_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= s1_valid_ff;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ONE_COMPARE:  one_cmp_ff  <= csr_data;
               CSR_ZERO_COMPARE: zero_cmp_ff <= csr_data;
               default:          one_cmp_ff  <= one_cmp_ff;
            endcase
         end
      end
   end

   // colour store, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         colour_mem[clr_cnt_ff] <= '0;
      end else if (wr_en) begin
         colour_mem[cmd.led_index[LED_IDX_W-1:0]] <= cmd.colour;
      end
      rd_data_ff <= colour_mem[led_ff];
   end

   always_ff @(posedge clock) begin
      s1_gap_ff  <= (phase_ff == PH_GAP);
      s1_fend_ff <= last_gap;
      s1_bit_ff  <= bit_ff;
      rsp_fend_ff <= s1_fend_ff;
      if (s1_gap_ff) begin
         rsp_cmp_ff <= '0;
      end else begin
         rsp_cmp_ff <= rd_data_ff[s1_bit_ff] ? one_cmp_ff : zero_cmp_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_compare_value = rsp_cmp_ff;
   assign rsp_frame_end     = rsp_fend_ff;

endmodule

// File: hdl/ws2812_frame_serializer.sv
// ws2812 frame serializer: a write transaction (opcode 0) stores green, red and blue for one
// led and gives no result; a tick transaction (opcode 1) gives one pwm compare value, shown
// with rsp_valid for exactly one cycle, registered through the queue, the s1 stage and
// the response register, since the receiver cannot stall. one transaction is taken per
// cycle outside the clearing pass, set by the back end, which carries out one queued
// transaction per cycle; the queue never fills in normal operation. after reset busy stays
// high while the colour store is cleared to black; csr writes are taken at all times but
// should only be made while no transaction is in flight.
module ws2812_frame_serializer #(
   parameter int unsigned LED_COUNT   = 8,
   parameter int unsigned RESET_SLOTS = 60
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_opcode,
   input  logic [9:0] req_led_index,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   output logic [7:0] rsp_compare_value,
   output logic       rsp_frame_end,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [0:0] csr_index,
   input  logic [7:0] csr_data
);
   import wsfs_pkg::*;

   cmd_type        front_cmd;
   cmd_type        queue_cmd;
   queue_stat_type queue_stat;
   logic           push;
   logic           pop;
   logic           clearing;

   wsfs_front #(
      .LED_COUNT (LED_COUNT)
   ) u_front (
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_led_index (req_led_index),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .queue_stat    (queue_stat),
      .clearing      (clearing),
      .push          (push),
      .cmd           (front_cmd)
   );

   wsfs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .cmd_in  (front_cmd),
      .cmd_out (queue_cmd),
      .stat    (queue_stat)
   );

   wsfs_back #(
      .LED_COUNT   (LED_COUNT),
      .RESET_SLOTS (RESET_SLOTS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd               (queue_cmd),
      .queue_stat        (queue_stat),
      .pop               (pop),
      .clearing          (clearing),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_compare_value (rsp_compare_value),
      .rsp_frame_end     (rsp_frame_end)
   );

endmodule

// File: hdl/wsfs_checker.sv
module wsfs_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_opcode,
   input logic       rsp_valid,
   input logic [7:0] rsp_compare_value,
   input logic       rsp_frame_end
);
   import wsfs_pkg::*;

   // every tick transaction gives a result
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_TICK) |-> ##3 rsp_valid)
      else $error("tick transaction without result");

   // a write transaction never gives a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_WRITE) |-> ##3 !rsp_valid)
      else $error("write transaction gave a result");

   // frame end only falls in a gap slot, which sends zero
   a_frame_end_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> (rsp_compare_value == 8'd0))
      else $error("frame end on a data slot");

   // colour store clearing holds off transactions right after reset
   a_clear_busy: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("not busy during clearing pass");

endmodule

bind ws2812_frame_serializer wsfs_checker u_wsfs_checker (.*);
